@@ design/hpr_pkg.sv @@
// Shared types, codes and the CRC-16/XMODEM byte update for the hello-packet receiver.
// No dependencies; imported by every module of the block.
package hpr_pkg;

  localparam int unsigned PKT_BYTES_DEFAULT = 128;

  localparam logic [7:0] LEAD_BYTE = 8'h1F;
  localparam logic [7:0] CODE_ENQ  = 8'h05;
  localparam logic [7:0] CODE_ACK  = 8'h06;
  localparam logic [7:0] CODE_NAK  = 8'h3F;

  localparam logic [4:0] ENQ_LIMIT_RESET = 5'd12;
  localparam logic [4:0] NAK_LIMIT_RESET = 5'd9;
  localparam logic [7:0] HELLO_RESET     = 8'd241;

  localparam int unsigned RETRY_W = 6;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    EV_START   = 2'd0,
    EV_BYTE    = 2'd1,
    EV_TIMEOUT = 2'd2,
    EV_LINEERR = 2'd3
  } event_kind_t;

  typedef enum logic [1:0] {
    OUTCOME_NONE    = 2'd0,
    OUTCOME_SUCCESS = 2'd1,
    OUTCOME_FAILURE = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_RETRIES  = 2'd1,
    CAUSE_LINEERR  = 2'd2,
    CAUSE_TIMEOUT  = 2'd3
  } fail_cause_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENQ_LIMIT = 2'd0,
    REG_NAK_LIMIT = 2'd1,
    REG_HELLO     = 2'd2
  } cfg_reg_t;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_WAIT = 6'b000010,
    PH_DATA = 6'b000100,
    PH_CRCH = 6'b001000,
    PH_CRCL = 6'b010000,
    PH_DONE = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       data_valid;
    logic [6:0] data_index;
    logic [7:0] data_byte;
    logic [1:0] outcome;
    logic [1:0] fail_cause;
  } out_t;

  typedef struct packed {
    logic [4:0] enq_retry_limit;
    logic [4:0] nak_retry_limit;
    logic [7:0] hello_code;
  } cfg_t;

  // CRC-16/XMODEM: poly 0x1021, MSB first, one byte
  function automatic logic [15:0] crc16_byte(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ 16'h1021;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ design/hpr_cfg.sv @@
// Configuration register file: retry limits and hello byte.
// Depends on hpr_pkg.
module hpr_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [hpr_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [7:0]                      wr_data,
  output hpr_pkg::cfg_t                   cfg
);
  import hpr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enq_retry_limit <= ENQ_LIMIT_RESET;
      cfg.nak_retry_limit <= NAK_LIMIT_RESET;
      cfg.hello_code      <= HELLO_RESET;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_ENQ_LIMIT: cfg.enq_retry_limit <= wr_data[4:0];
        REG_NAK_LIMIT: cfg.nak_retry_limit <= wr_data[4:0];
        REG_HELLO:     cfg.hello_code      <= wr_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

@@ design/hpr_core.sv @@
// Handshake state machine: phase, retry count, byte position and CRC state,
// plus the combinational result for the item being processed. Depends on hpr_pkg.
module hpr_core #(
  parameter int unsigned PACKET_BYTES = hpr_pkg::PKT_BYTES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  hpr_pkg::in_t   item,
  input  hpr_pkg::cfg_t  cfg,
  output hpr_pkg::out_t  res
);
  import hpr_pkg::*;

  localparam int unsigned POS_W = $clog2(PACKET_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);

  phase_t             phase, phase_next;
  logic [RETRY_W-1:0] retry_count, retry_count_next;
  logic [POS_W-1:0]   byte_position, byte_position_next;
  logic [15:0]        running_crc, running_crc_next;
  logic [7:0]         crc_high_byte, crc_high_byte_next;

  logic               do_retry;
  logic [4:0]         retry_limit;
  logic [7:0]         retry_code;
  logic [7:0]         pos_ext;
  logic [RETRY_W-1:0] count_seen;

  assign pos_ext = 8'(byte_position);

  always_comb begin
    phase_next         = phase;
    retry_count_next   = retry_count;
    byte_position_next = byte_position;
    running_crc_next   = running_crc;
    crc_high_byte_next = crc_high_byte;
    res         = '0;
    do_retry    = 1'b0;
    retry_limit = cfg.enq_retry_limit;
    retry_code  = CODE_ENQ;
    count_seen  = retry_count;

    if (item.event_kind == EV_START) begin
      // start clears everything, then sends ENQ
      count_seen         = '0;
      byte_position_next = '0;
      running_crc_next   = '0;
      crc_high_byte_next = '0;
      do_retry           = 1'b1;
    end else if (phase == PH_IDLE || phase == PH_DONE) begin
      // nothing to do until a start
    end else if (item.event_kind == EV_LINEERR) begin
      phase_next     = PH_DONE;
      res.outcome    = OUTCOME_FAILURE;
      res.fail_cause = CAUSE_LINEERR;
    end else if (phase == PH_WAIT) begin
      if (item.event_kind == EV_TIMEOUT) begin
        do_retry = 1'b1;
      end else if (item.rx_byte == LEAD_BYTE) begin
        phase_next         = PH_DATA;
        byte_position_next = '0;
        running_crc_next   = '0;
      end else if (item.rx_byte == cfg.hello_code) begin
        do_retry = 1'b1;
      end
    end else if (item.event_kind == EV_TIMEOUT) begin
      phase_next     = PH_DONE;
      res.outcome    = OUTCOME_FAILURE;
      res.fail_cause = CAUSE_TIMEOUT;
    end else begin
      case (phase)
        PH_DATA: begin
          res.data_valid   = 1'b1;
          res.data_index   = pos_ext[6:0];
          res.data_byte    = item.rx_byte;
          running_crc_next = crc16_byte(running_crc, item.rx_byte);
          if (byte_position == LAST_POS) begin
            phase_next         = PH_CRCH;
            byte_position_next = '0;
          end else begin
            byte_position_next = byte_position + 1'b1;
          end
        end
        PH_CRCH: begin
          crc_high_byte_next = item.rx_byte;
          phase_next         = PH_CRCL;
        end
        PH_CRCL: begin
          if ({crc_high_byte, item.rx_byte} == running_crc) begin
            res.send_valid = 1'b1;
            res.send_byte  = CODE_ACK;
            res.outcome    = OUTCOME_SUCCESS;
            phase_next     = PH_DONE;
          end else begin
            do_retry    = 1'b1;
            retry_limit = cfg.nak_retry_limit;
            retry_code  = CODE_NAK;
          end
        end
        default: ;
      endcase
    end

    // shared retry test: count checked before it is raised
    if (do_retry) begin
      if (count_seen > {1'b0, retry_limit}) begin
        retry_count_next = count_seen;
        phase_next       = PH_DONE;
        res.outcome      = OUTCOME_FAILURE;
        res.fail_cause   = CAUSE_RETRIES;
      end else begin
        retry_count_next = count_seen + 1'b1;
        res.send_valid   = 1'b1;
        res.send_byte    = retry_code;
        phase_next       = PH_WAIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      retry_count   <= '0;
      byte_position <= '0;
      running_crc   <= '0;
      crc_high_byte <= '0;
    end else if (step) begin
      phase         <= phase_next;
      retry_count   <= retry_count_next;
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      crc_high_byte <= crc_high_byte_next;
    end
  end

  a_send_xor_data: assert property (@(posedge clk) disable iff (rst)
    step && res.data_valid |-> !res.send_valid && res.outcome == OUTCOME_NONE)
    else $error("data byte passed on together with a send or an outcome");

  a_fail_ends: assert property (@(posedge clk) disable iff (rst)
    step && res.outcome != OUTCOME_NONE |=> phase == PH_DONE)
    else $error("exchange ended but phase is not done");

  a_data_phase: assert property (@(posedge clk) disable iff (rst)
    step && res.data_valid |-> phase == PH_DATA)
    else $error("data byte passed on outside the data phase");

  a_retry_bound: assert property (@(posedge clk) disable iff (rst)
    retry_count <= 6'd32)
    else $error("retry count ran past its limit");

endmodule

@@ design/hello_packet_receiver.sv @@
// Hello-packet receiver top level: input register, handshake core, result register.
// Depends on hpr_pkg, hpr_cfg and hpr_core.
//
// Answering side of a hello-packet handshake. Each event (start, received byte,
// timeout, line error) produces exactly one result transaction carrying the byte
// to send (ENQ, ACK or '?'), the passed-on packet data byte with its position,
// and the exchange outcome with its failure cause. One event is taken every
// clock cycle while item_stall is low. The accepting edge loads the input register,
// and the result register is loaded from it when the item advances, which a stalled
// result can hold back. The per-byte CRC-16/XMODEM update with the state change is
// done combinationally between the two registers. A stalled result holds the
// pipeline; item_stall then rises once the input register is also full.
// Configuration writes are always accepted and must only be made while idle.
module hello_packet_receiver #(
  parameter int unsigned PACKET_BYTES = hpr_pkg::PKT_BYTES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  hpr_pkg::in_t                    item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output hpr_pkg::out_t                   result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hpr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                      cfg_data
);
  import hpr_pkg::*;

  cfg_t cfg;
  in_t  s1_item;
  logic s1_valid;
  logic advance;
  out_t core_res;

  assign cfg_ready = 1'b1;

  hpr_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // item in the input register moves on when the result register is free
  assign advance    = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  hpr_core #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (s1_item),
    .cfg  (cfg),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_res;
    end
  end

endmodule
